@@ sv/vit_pkg.sv @@
// ----------------------------------------------------------------------------
// vit_pkg: shared types and constants of the vsync interval tracker
// Holds default parameter values, register indexes, reset values, the
// fixed-point weights of the drift average, function codes and states.
// ----------------------------------------------------------------------------
package vit_pkg;

  // Default parameter values.
  localparam int HistoryDepthDefault = 10;
  localparam int TimeBitsDefault     = 48;

  // Configuration register indexes.
  localparam logic [7:0] CFG_DRIFT_WINDOW   = 8'd0;
  localparam logic [7:0] CFG_STATS_FALLBACK = 8'd1;
  localparam logic [7:0] CFG_QUERY_FALLBACK = 8'd2;
  localparam logic [7:0] CFG_HALF_VBLANK    = 8'd3;

  // Register reset values.
  localparam logic [15:0] DRIFT_WINDOW_RST   = 16'd300;
  localparam logic [31:0] STATS_FALLBACK_RST = 32'd166667;
  localparam logic [31:0] QUERY_FALLBACK_RST = 32'd166667;

  // Drift average weights in Q16: keep = 1 - 0.05, alpha = 0.05.
  localparam logic [15:0]        KEEP_Q16  = 16'd62259;
  localparam logic signed [13:0] ALPHA_Q16 = 14'sd3277;

  // Drift average reset: one tick in signed Q24.16.
  localparam logic signed [39:0] DRIFT_RST = 40'sd65536;

  // Function codes of an input item.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Sequencer states.
  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_EVAL    = 11'b000_0000_0010,
    ST_MUL     = 11'b000_0000_0100,
    ST_DRIFT   = 11'b000_0000_1000,
    ST_CHKIV   = 11'b000_0001_0000,
    ST_IVDIV   = 11'b000_0010_0000,
    ST_HIST    = 11'b000_0100_0000,
    ST_AVGDIV  = 11'b000_1000_0000,
    ST_QDIV    = 11'b001_0000_0000,
    ST_HALF    = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_e;

endpackage

@@ sv/vit_ram.sv @@
// ----------------------------------------------------------------------------
// vit_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/vit_div.sv @@
// ----------------------------------------------------------------------------
// vit_div: bit-serial restoring divider
// Divides a DW-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vit_div #(
  parameter int DW = 48,
  localparam int CW = $clog2(DW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [31:0]   divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o,
  output logic [31:0]   remainder_o
);

  logic [31:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [31:0]   den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [32:0]   shifted;
  logic          fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    fits    = (shifted >= {1'b0, den_q});
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? 32'(shifted - {1'b0, den_q}) : shifted[31:0];
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ sv/vsync_interval_tracker_core.sv @@
// ----------------------------------------------------------------------------
// vsync_interval_tracker_core: vsync interval and next-vblank estimator
// Tracks a moving average of vsync intervals and a slow drift average, and
// answers next-vblank queries.
//
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+------------------------------------
//   in       | in_valid_i / in_ready_o  | func, stats_valid, refresh_count,
//            |                          | sync_time, prior_target, now_time
//   out      | out_valid_o / out_ready_i| avg_interval, drift_ticks,
//            |                          | next_vblank, display_period
//   cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item is in work at a time. A valid sample may run a serial multiply
// over the 16 bits of the keep weight for the drift average and up to two
// passes of the bit-serial divider (DW = max(TIME_BITS, sum width)). A
// query uses at most one divider pass. The result sits in an output
// register; a stalled output holds the sequencer at its last step. Reset
// needs no clearing pass.
// ----------------------------------------------------------------------------
module vsync_interval_tracker_core #(
  parameter int HISTORY_DEPTH = vit_pkg::HistoryDepthDefault,
  parameter int TIME_BITS     = vit_pkg::TimeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input item channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic                 stats_valid_i,
  input  logic [31:0]          refresh_count_i,
  input  logic [TIME_BITS-1:0] sync_time_i,
  input  logic [TIME_BITS-1:0] prior_target_i,
  input  logic [TIME_BITS-1:0] now_time_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          avg_interval_o,
  output logic signed [16:0]   drift_ticks_o,
  output logic [TIME_BITS-1:0] next_vblank_o,
  output logic [31:0]          display_period_o,
  // Configuration channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int T     = TIME_BITS;
  localparam int FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int PW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SW    = 32 + FW;
  localparam int DW    = (T > SW) ? T : SW;
  localparam int MW    = 56;
  localparam logic signed [29:0] ALPHA_WIDE = 30'(vit_pkg::ALPHA_Q16);

  vit_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] win_q;
  logic [31:0] sfi_q;
  logic [31:0] qfi_q;
  logic        half_q;

  // Tracking state.
  logic [31:0]        last_refresh_q, last_refresh_d;
  logic [T-1:0]       last_sync_q, last_sync_d;
  logic signed [39:0] drift_q, drift_d;
  logic [SW-1:0]      sum_q, sum_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [31:0]        avg_q, avg_d;

  // Item registers.
  logic               func_q;
  logic               sv_q;
  logic [31:0]        rc_q;
  logic [T-1:0]       st_q;
  logic [T-1:0]       pt_q;
  logic [T-1:0]       now_q;
  logic [31:0]        src_q, src_d;
  logic [T-1:0]       elap_q, elap_d;
  logic               ivok_q, ivok_d;
  logic [15:0]        dmag_q, dmag_d;
  logic               dneg_q, dneg_d;
  logic signed [MW-1:0] acc_q, acc_d;
  logic signed [MW-1:0] mcand_q, mcand_d;
  logic [3:0]         mcnt_q, mcnt_d;
  logic [31:0]        iv_q, iv_d;
  logic [T-1:0]       target_q, target_d;
  logic [31:0]        period_q, period_d;

  // Output register.
  logic               ovalid_q, ovalid_d;
  logic [31:0]        oavg_q, oavg_d;
  logic signed [16:0] odt_q, odt_d;
  logic [T-1:0]       onext_q, onext_d;
  logic [31:0]        oper_q, oper_d;

  // Divider and history memory hookup.
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [31:0]   div_divisor;
  logic          div_busy;
  logic [DW-1:0] div_quo;
  logic [31:0]   div_rem;
  logic          ram_we;
  logic [31:0]   ram_rdata;

  // Combinational helpers.
  logic signed [23:0] dt_full;
  logic [T-1:0]       ediff;
  logic [T-1:0]       ddiff;
  logic [T-1:0]       dmag_full;
  logic [T-1:0]       next_t;
  logic [T-1:0]       qdiff;
  logic [T-1:0]       t2;
  logic [T-1:0]       t2diff;
  logic [31:0]        half_iv;
  logic signed [16:0] d_s;
  logic signed [29:0] dprod;
  logic signed [MW-1:0] num;
  logic [31:0]        iv_sat;
  logic [SW-1:0]      sum_new;
  logic [FW-1:0]      fill_new;

  vit_div #(.DW(DW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  vit_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (iv_q),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // Drift average truncated toward zero to whole ticks.
  assign dt_full = drift_q[39:16] +
                   24'((drift_q[39] && (drift_q[15:0] != 16'd0)) ? 1 : 0);

  // Time differences on the latched item.
  assign ediff     = st_q - last_sync_q;
  assign ddiff     = st_q - pt_q;
  assign dmag_full = ddiff[T-1] ? (T'(0) - ddiff) : ddiff;
  assign next_t    = last_sync_q + T'(dt_full);
  assign qdiff     = now_q - next_t;
  assign half_iv   = {1'b0, iv_q[31:1]};
  assign t2        = target_q - T'(half_iv);
  assign t2diff    = t2 - now_q;

  // Drift update terms.
  assign d_s   = dneg_q ? (17'sd0 - $signed({1'b0, dmag_q})) : $signed({1'b0, dmag_q});
  assign dprod = d_s * ALPHA_WIDE;
  assign num   = acc_q + $signed({{10{dprod[29]}}, dprod, 16'b0}) + MW'(32768);

  // Saturated interval and new history totals.
  assign iv_sat   = (div_quo[DW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
  assign sum_new  = ((fill_q >= FW'(HISTORY_DEPTH)) ? (sum_q - SW'(ram_rdata)) : sum_q)
                    + SW'(iv_q);
  assign fill_new = (fill_q >= FW'(HISTORY_DEPTH)) ? fill_q : (fill_q + FW'(1));

  // Sequencer.
  always_comb begin
    state_d        = state_q;
    last_refresh_d = last_refresh_q;
    last_sync_d    = last_sync_q;
    drift_d        = drift_q;
    sum_d          = sum_q;
    fill_d         = fill_q;
    pos_d          = pos_q;
    avg_d          = avg_q;
    src_d          = src_q;
    elap_d         = elap_q;
    ivok_d         = ivok_q;
    dmag_d         = dmag_q;
    dneg_d         = dneg_q;
    acc_d          = acc_q;
    mcand_d        = mcand_q;
    mcnt_d         = mcnt_q;
    iv_d           = iv_q;
    target_d       = target_q;
    period_d       = period_q;
    ovalid_d       = ovalid_q;
    oavg_d         = oavg_q;
    odt_d          = odt_q;
    onext_d        = onext_q;
    oper_d         = oper_q;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;
    ram_we         = 1'b0;

    // The output register empties on a transfer.
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      vit_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = vit_pkg::ST_EVAL;
        end
      end

      vit_pkg::ST_EVAL: begin
        target_d = '0;
        period_d = '0;
        if (func_q == vit_pkg::FUNC_SAMPLE) begin
          if (!sv_q) begin
            // Statistics unavailable: fall back.
            last_sync_d = now_q;
            avg_d       = sfi_q;
            state_d     = vit_pkg::ST_DONE;
          end else begin
            src_d  = (rc_q != 32'd0 && last_refresh_q != 32'd0) ?
                     (rc_q - last_refresh_q) : 32'd0;
            elap_d = (st_q != '0 && last_sync_q != '0) ? ediff : '0;
            ivok_d = (st_q != '0 && last_sync_q != '0) && !ediff[T-1] && (ediff != '0);
            last_refresh_d = rc_q;
            last_sync_d    = st_q;
            dmag_d  = dmag_full[15:0];
            dneg_d  = ddiff[T-1];
            acc_d   = '0;
            mcand_d = MW'(drift_q);
            mcnt_d  = '0;
            if (pt_q != '0 && dmag_full < T'(win_q)) begin
              state_d = vit_pkg::ST_MUL;
            end else begin
              state_d = vit_pkg::ST_CHKIV;
            end
          end
        end else begin
          if (last_sync_q == '0 || avg_q == 32'd0) begin
            iv_d     = qfi_q;
            target_d = now_q + T'(qfi_q);
            state_d  = vit_pkg::ST_HALF;
          end else begin
            iv_d = avg_q;
            if (!qdiff[T-1] && qdiff != '0) begin
              div_start    = 1'b1;
              div_dividend = DW'(qdiff);
              div_divisor  = avg_q;
              state_d      = vit_pkg::ST_QDIV;
            end else begin
              target_d = next_t;
              state_d  = vit_pkg::ST_HALF;
            end
          end
        end
      end

      // Serial shift-add of the drift average by the keep weight.
      vit_pkg::ST_MUL: begin
        if (vit_pkg::KEEP_Q16[mcnt_q]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d = mcand_q <<< 1;
        mcnt_d  = mcnt_q + 4'd1;
        if (mcnt_q == 4'd15) begin
          state_d = vit_pkg::ST_DRIFT;
        end
      end

      vit_pkg::ST_DRIFT: begin
        drift_d = num[55:16];
        state_d = vit_pkg::ST_CHKIV;
      end

      vit_pkg::ST_CHKIV: begin
        if (src_q != 32'd0 && ivok_q) begin
          div_start    = 1'b1;
          div_dividend = DW'(elap_q);
          div_divisor  = src_q;
          state_d      = vit_pkg::ST_IVDIV;
        end else begin
          state_d = vit_pkg::ST_DONE;
        end
      end

      vit_pkg::ST_IVDIV: begin
        if (!div_busy) begin
          iv_d    = iv_sat;
          state_d = vit_pkg::ST_HIST;
        end
      end

      // Write the new interval (over the oldest once full) and start the mean.
      vit_pkg::ST_HIST: begin
        ram_we       = 1'b1;
        sum_d        = sum_new;
        fill_d       = fill_new;
        pos_d        = (pos_q == PW'(HISTORY_DEPTH - 1)) ? '0 : (pos_q + PW'(1));
        div_start    = 1'b1;
        div_dividend = DW'(sum_new);
        div_divisor  = 32'(fill_new);
        state_d      = vit_pkg::ST_AVGDIV;
      end

      vit_pkg::ST_AVGDIV: begin
        if (!div_busy) begin
          avg_d   = div_quo[31:0];
          state_d = vit_pkg::ST_DONE;
        end
      end

      // Round up to the next whole interval at or after now.
      vit_pkg::ST_QDIV: begin
        if (!div_busy) begin
          target_d = now_q + ((div_rem != 32'd0) ? T'(iv_q - div_rem) : '0);
          state_d  = vit_pkg::ST_HALF;
        end
      end

      vit_pkg::ST_HALF: begin
        if (half_q) begin
          period_d = half_iv;
          if (!t2diff[T-1] && t2diff != '0) begin
            target_d = t2;
          end
        end else begin
          period_d = iv_q;
        end
        state_d = vit_pkg::ST_DONE;
      end

      vit_pkg::ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oavg_d   = avg_q;
          odt_d    = dt_full[16:0];
          onext_d  = target_q;
          oper_d   = period_q;
          state_d  = vit_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = vit_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and tracking state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= vit_pkg::ST_IDLE;
      ovalid_q       <= 1'b0;
      last_refresh_q <= '0;
      last_sync_q    <= '0;
      drift_q        <= vit_pkg::DRIFT_RST;
      sum_q          <= '0;
      fill_q         <= '0;
      pos_q          <= '0;
      avg_q          <= '0;
      mcnt_q         <= '0;
    end else begin
      state_q        <= state_d;
      ovalid_q       <= ovalid_d;
      last_refresh_q <= last_refresh_d;
      last_sync_q    <= last_sync_d;
      drift_q        <= drift_d;
      sum_q          <= sum_d;
      fill_q         <= fill_d;
      pos_q          <= pos_d;
      avg_q          <= avg_d;
      mcnt_q         <= mcnt_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= vit_pkg::DRIFT_WINDOW_RST;
      sfi_q  <= vit_pkg::STATS_FALLBACK_RST;
      qfi_q  <= vit_pkg::QUERY_FALLBACK_RST;
      half_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vit_pkg::CFG_DRIFT_WINDOW:   win_q  <= cfg_data_i[15:0];
        vit_pkg::CFG_STATS_FALLBACK: sfi_q  <= cfg_data_i;
        vit_pkg::CFG_QUERY_FALLBACK: qfi_q  <= cfg_data_i;
        vit_pkg::CFG_HALF_VBLANK:    half_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      sv_q   <= stats_valid_i;
      rc_q   <= refresh_count_i;
      st_q   <= sync_time_i;
      pt_q   <= prior_target_i;
      now_q  <= now_time_i;
    end
    src_q    <= src_d;
    elap_q   <= elap_d;
    ivok_q   <= ivok_d;
    dmag_q   <= dmag_d;
    dneg_q   <= dneg_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    iv_q     <= iv_d;
    target_q <= target_d;
    period_q <= period_d;
    oavg_q   <= oavg_d;
    odt_q    <= odt_d;
    onext_q  <= onext_d;
    oper_q   <= oper_d;
  end

  assign in_ready_o       = (state_q == vit_pkg::ST_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = ovalid_q;
  assign avg_interval_o   = oavg_q;
  assign drift_ticks_o    = odt_q;
  assign next_vblank_o    = onext_q;
  assign display_period_o = oper_q;

endmodule
